// ----- hdl/lidar_point_camera_view_filter_assert.svh -----
// ----------------------------------------------------------------------------
// lidar_point_camera_view_filter_assert.svh
// Assertion macros for the camera-view filter checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_VIEW_FILTER_ASSERT_SVH
`define LIDAR_POINT_CAMERA_VIEW_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LPCVF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcvf assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define LPCVF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcvf assertion failed");

`endif

// ----- hdl/lpcvf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcvf_pkg
// Shared types and constants of the lidar camera-view filter.
// ----------------------------------------------------------------------------
package lpcvf_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int MAT_W      = 32;   // matrix entry, signed Q16.16
    localparam int MAT_REGS   = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int HALF_W     = 15;   // image size >> 1
    localparam int PIPE_DEPTH = 6;

    localparam logic [15:0] WIDTH_RESET  = 16'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01,
        REG_ROW0_COLS23,
        REG_ROW1_COLS01,
        REG_ROW1_COLS23,
        REG_ROW2_COLS01,
        REG_ROW2_COLS23,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [MAT_REGS-1:0][CFG_DATA_W-1:0] mat;
        logic [HALF_W-1:0]                   half_w;
        logic [HALF_W-1:0]                   half_h;
    } cfg_t;

    // exact width of one projected row: largest term plus two carry bits
    function automatic int sum_width(input int cw, input int fb);
        int pw;
        int tw;
        pw = MAT_W + cw;
        tw = MAT_W + fb;
        return ((pw > tw) ? pw : tw) + 2;
    endfunction

endpackage

// ----- hdl/lpcvf_cfg.sv -----
// ----------------------------------------------------------------------------
// lpcvf_cfg
// Configuration registers: camera matrix and image size.
// ----------------------------------------------------------------------------
module lpcvf_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpcvf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpcvf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lpcvf_pkg::cfg_t                    cfg
);

    logic [lpcvf_pkg::MAT_REGS-1:0][lpcvf_pkg::CFG_DATA_W-1:0] mat_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg    <= '0;
            width_reg  <= lpcvf_pkg::WIDTH_RESET;
            height_reg <= lpcvf_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lpcvf_pkg::reg_idx_t'(cfg_index))
                lpcvf_pkg::REG_ROW0_COLS01:  mat_reg[0] <= cfg_data;
                lpcvf_pkg::REG_ROW0_COLS23:  mat_reg[1] <= cfg_data;
                lpcvf_pkg::REG_ROW1_COLS01:  mat_reg[2] <= cfg_data;
                lpcvf_pkg::REG_ROW1_COLS23:  mat_reg[3] <= cfg_data;
                lpcvf_pkg::REG_ROW2_COLS01:  mat_reg[4] <= cfg_data;
                lpcvf_pkg::REG_ROW2_COLS23:  mat_reg[5] <= cfg_data;
                lpcvf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[15:0];
                lpcvf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[15:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    assign cfg.mat    = mat_reg;
    assign cfg.half_w = width_reg[15:1];
    assign cfg.half_h = height_reg[15:1];

endmodule

// ----- hdl/lpcvf_proj.sv -----
// ----------------------------------------------------------------------------
// lpcvf_proj
// Projection Y = M * [x y z 1]: products, pair sums, row sums (3 stages).
// ----------------------------------------------------------------------------
module lpcvf_proj #(
    parameter int COORD_WIDTH = lpcvf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lpcvf_pkg::FRAC_BITS_DEF,
    parameter int SUM_W       = lpcvf_pkg::sum_width(COORD_WIDTH, FRAC_BITS)
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  lpcvf_pkg::cfg_t               cfg,
    output logic signed [SUM_W-1:0]       y0,
    output logic signed [SUM_W-1:0]       y1,
    output logic signed [SUM_W-1:0]       y2
);

    localparam int PROD_W = lpcvf_pkg::MAT_W + COORD_WIDTH;
    localparam int TERM_W = lpcvf_pkg::MAT_W + FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [TERM_W-1:0] term_reg [3];
    logic signed [SUM_W-1:0]  lo_reg   [3];
    logic signed [SUM_W-1:0]  hi_reg   [3];
    logic signed [SUM_W-1:0]  row_reg  [3];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        localparam int R01 = 2 * r;
        localparam int R23 = 2 * r + 1;

        logic signed [lpcvf_pkg::MAT_W-1:0] m0, m1, m2, m3;

        assign m0 = $signed(cfg.mat[R01][31:0]);
        assign m1 = $signed(cfg.mat[R01][63:32]);
        assign m2 = $signed(cfg.mat[R23][31:0]);
        assign m3 = $signed(cfg.mat[R23][63:32]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // stage 1: one multiplier per matrix entry of columns 0 to 2, a shift for column 3
                prod_reg[r][0] <= PROD_W'(m0) * PROD_W'(point_x);
                prod_reg[r][1] <= PROD_W'(m1) * PROD_W'(point_y);
                prod_reg[r][2] <= PROD_W'(m2) * PROD_W'(point_z);
                term_reg[r]    <= TERM_W'(m3) <<< FRAC_BITS;   // times 1.0
                // stage 2
                lo_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]);
                hi_reg[r] <= SUM_W'(prod_reg[r][2]) + SUM_W'(term_reg[r]);
                // stage 3
                row_reg[r] <= lo_reg[r] + hi_reg[r];
            end
        end
    end

    assign y0 = row_reg[0];
    assign y1 = row_reg[1];
    assign y2 = row_reg[2];

endmodule

// ----- hdl/lpcvf_win.sv -----
// ----------------------------------------------------------------------------
// lpcvf_win
// Window test without division: sign fold, bound product, compare (3 stages).
// ----------------------------------------------------------------------------
module lpcvf_win #(
    parameter int COORD_WIDTH = lpcvf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lpcvf_pkg::FRAC_BITS_DEF,
    parameter int SUM_W       = lpcvf_pkg::sum_width(COORD_WIDTH, FRAC_BITS)
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [SUM_W-1:0]  y0,
    input  logic signed [SUM_W-1:0]  y1,
    input  logic signed [SUM_W-1:0]  y2,
    input  lpcvf_pkg::cfg_t          cfg,
    output logic                     keep
);

    localparam int N_W = SUM_W + 1;                    // negated row still fits
    localparam int B_W = SUM_W + lpcvf_pkg::HALF_W;    // |Y2| * half size
    localparam int C_W = B_W + 2;

    logic                     flip;
    logic [SUM_W-1:0]         d_reg;
    logic signed [N_W-1:0]    nu_reg, nv_reg;
    logic [B_W-1:0]           bu_reg, bv_reg;
    logic signed [N_W-1:0]    nu5_reg, nv5_reg;
    logic signed [C_W-1:0]    cu, cv, su, sv, bus, bvs;
    logic                     keep_reg;

    assign flip = y2[SUM_W-1];

    // stage 6 operands
    assign cu  = C_W'(nu5_reg);
    assign cv  = C_W'(nv5_reg);
    assign bus = $signed(C_W'(bu_reg));
    assign bvs = $signed(C_W'(bv_reg));
    assign su  = cu + bus;
    assign sv  = cv + bvs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 4: fold the sign of Y2 into the numerators
            d_reg  <= flip ? SUM_W'(-y2) : SUM_W'(y2);
            nu_reg <= flip ? -N_W'(y0) : N_W'(y0);
            nv_reg <= flip ? -N_W'(y1) : N_W'(y1);
            // stage 5: window bounds
            bu_reg  <= B_W'(d_reg) * B_W'(cfg.half_w);
            bv_reg  <= B_W'(d_reg) * B_W'(cfg.half_h);
            nu5_reg <= nu_reg;
            nv5_reg <= nv_reg;
            // stage 6: -B <= N < B; Y2 == 0 gives B == 0, an empty window
            keep_reg <= !su[C_W-1] && (cu < bus) && !sv[C_W-1] && (cv < bvs);
        end
    end

    assign keep = keep_reg;

endmodule

// ----- hdl/lidar_point_camera_view_filter.sv -----
// Each accepted point passes through the pipeline stages mapped below to the output.
// Throughput: one point per cycle; every stage holds while a finished item is stalled.
// in_stall rises only while a result waits at the output under out_stall.
// Reset (rst_n, async, active low) empties the pipeline; matrix clears to zero,
// image size returns to 640 x 480. No clearing pass.
// ----------------------------------------------------------------------------
// lidar_point_camera_view_filter
// Pinhole projection frustum filter: tags each lidar point with a keep flag.
// ----------------------------------------------------------------------------
module lidar_point_camera_view_filter #(
    parameter int COORD_WIDTH = lpcvf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lpcvf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // point input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    input  logic                              frame_end,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_WIDTH-1:0]     out_x,
    output logic signed [COORD_WIDTH-1:0]     out_y,
    output logic signed [COORD_WIDTH-1:0]     out_z,
    output logic                              keep,
    output logic                              out_frame_end,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpcvf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpcvf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = lpcvf_pkg::sum_width(COORD_WIDTH, FRAC_BITS);
    localparam int DEPTH = lpcvf_pkg::PIPE_DEPTH;

    // Pipeline map:
    //   1  nine Q16.16 x coordinate products, translation term
    //   2  pair sums per row
    //   3  row sums Y0, Y1, Y2 (exact, no rounding)
    //   4  D = |Y2|, numerators negated when Y2 < 0
    //   5  bounds D*floor(w/2), D*floor(h/2)
    //   6  -B <= N < B for both axes -> keep (output register)
    // The point itself rides alongside in a shift line with the valid bits.

    lpcvf_pkg::cfg_t         cfg;
    logic                    en;
    logic signed [SUM_W-1:0] y0, y1, y2;

    logic                          valid_reg [DEPTH];
    logic signed [COORD_WIDTH-1:0] x_reg     [DEPTH];
    logic signed [COORD_WIDTH-1:0] y_reg     [DEPTH];
    logic signed [COORD_WIDTH-1:0] z_reg     [DEPTH];
    logic                          fe_reg    [DEPTH];

    // Global advance: the whole pipe moves unless the last stage holds a
    // result the consumer is stalling. Bubbles never block.
    assign en       = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    lpcvf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpcvf_proj #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .SUM_W       (SUM_W)
    ) u_proj (
        .clk     (clk),
        .en      (en),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .cfg     (cfg),
        .y0      (y0),
        .y1      (y1),
        .y2      (y2)
    );

    lpcvf_win #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .SUM_W       (SUM_W)
    ) u_win (
        .clk  (clk),
        .en   (en),
        .y0   (y0),
        .y1   (y1),
        .y2   (y2),
        .cfg  (cfg),
        .keep (keep)
    );

    // valid bits: control, reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // point echo: payload, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= point_x;
            y_reg[0]  <= point_y;
            z_reg[0]  <= point_z;
            fe_reg[0] <= frame_end;
            for (int i = 1; i < DEPTH; i++)
            begin
                x_reg[i]  <= x_reg[i-1];
                y_reg[i]  <= y_reg[i-1];
                z_reg[i]  <= z_reg[i-1];
                fe_reg[i] <= fe_reg[i-1];
            end
        end
    end

    assign out_valid     = valid_reg[DEPTH-1];
    assign out_x         = x_reg[DEPTH-1];
    assign out_y         = y_reg[DEPTH-1];
    assign out_z         = z_reg[DEPTH-1];
    assign out_frame_end = fe_reg[DEPTH-1];

endmodule

// ----- hdl/lpcvf_chk.sv -----
// ----------------------------------------------------------------------------
// lpcvf_chk
// Port-level checks of the camera-view filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_point_camera_view_filter_assert.svh"

module lpcvf_chk #(
    parameter int COORD_WIDTH = lpcvf_pkg::COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH-1:0] out_x,
    input logic                          keep,
    input logic                          out_frame_end,
    input logic                          cfg_ready
);

    // register writes are never held off
    `LPCVF_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

    // input backs up only behind a stalled result
    `LPCVF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // a stalled result holds
    `LPCVF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(keep) && $stable(out_frame_end))

endmodule

bind lidar_point_camera_view_filter lpcvf_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lpcvf_chk (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar camera-view filter (pinhole frustum test).
//
// Points go in through the valid/stall input channel. Each accepted point
// queues one expected result. The directed list types in some keep flags;
// a bit-exact projection predictor works out the others from the bench's
// own copy of the camera matrix and image size. The checker compares each
// accepted result, field by field, with the oldest queued entry. The run
// starts with a short directed list and then goes through random phases.
// Each phase loads a new matrix and image size while the block is idle.
// Both channels get random gaps and stalls; some phases run with none.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpcvf_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int ONE_I        = 1 << FRAC_BITS_DEF;       // 1.0 in coordinate format
    localparam int ITEMS_PER_RUN = 128;
    localparam int RANDOM_RUNS  = 9;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;

    localparam logic [CW-1:0] ONE  = CW'(ONE_I);
    localparam logic [CW-1:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] CMIN = 32'h8000_0000;

    // register codes the block must ignore
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_IMAGE_HEIGHT) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] LAST_REG_CODE    = '1;

    // camera setups used by the directed list
    typedef enum logic [2:0] {
        VIEW_AS_RESET,      // nothing written: zero matrix, 640 x 480
        VIEW_PINHOLE,       // u = x/z, v = y/z, 640 x 480
        VIEW_NARROW,        // pinhole, one pixel wide
        VIEW_FLAT,          // pinhole, zero pixels high
        VIEW_EXTREME        // extreme matrix entries, 65535 x 65535
    } view_setting_t;

    // how a random phase builds its matrix
    typedef enum logic [1:0] {
        MIX_PINHOLE,
        MIX_FULL_RANDOM,
        MIX_SMALL_RANDOM
    } matrix_mix_t;

    typedef struct packed {
        view_setting_t setting;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic          fe;
        logic          typed;       // keep below is given, not predicted
        logic          keep_typed;
    } point_row_t;

    typedef struct {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic          keep_flag;
        logic          last_flag;
    } point_result_t;

    // Directed points. Keep is typed in where it is obvious: the reset
    // matrix rejects everything, the pinhole window edges, zero depth,
    // points behind the camera and empty windows. Extreme values go to the
    // predictor.
    localparam point_row_t DIRECTED_POINTS [25] = '{
        '{VIEW_AS_RESET, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0},
        '{VIEW_AS_RESET, CMAX, CMAX, CMAX, 1'b1, 1'b1, 1'b0},
        '{VIEW_AS_RESET, CMIN, CMIN, CMIN, 1'b0, 1'b1, 1'b0},
        '{VIEW_AS_RESET, ONE, ONE, ONE, 1'b1, 1'b1, 1'b0},
        // centered point, zero depth, behind the camera
        '{VIEW_PINHOLE, 32'h0, 32'h0, ONE, 1'b0, 1'b1, 1'b1},
        '{VIEW_PINHOLE, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0},
        '{VIEW_PINHOLE, ONE, ONE, 32'h0, 1'b1, 1'b1, 1'b0},
        '{VIEW_PINHOLE, 32'h0, 32'h0, CW'(-ONE_I), 1'b0, 1'b1, 1'b1},
        // window edges: low side inclusive, high side exclusive
        '{VIEW_PINHOLE, CW'(-320 * ONE_I), CW'(-240 * ONE_I), ONE, 1'b0, 1'b1, 1'b1},
        '{VIEW_PINHOLE, CW'(319 * ONE_I), CW'(239 * ONE_I), ONE, 1'b0, 1'b1, 1'b1},
        '{VIEW_PINHOLE, CW'(320 * ONE_I), 32'h0, ONE, 1'b0, 1'b1, 1'b0},
        '{VIEW_PINHOLE, 32'h0, CW'(240 * ONE_I), ONE, 1'b1, 1'b1, 1'b0},
        '{VIEW_PINHOLE, CW'(-321 * ONE_I), 32'h0, ONE, 1'b0, 1'b1, 1'b0},
        // negative depth mirrors the window
        '{VIEW_PINHOLE, CW'(320 * ONE_I), 32'h0, CW'(-ONE_I), 1'b0, 1'b1, 1'b1},
        '{VIEW_PINHOLE, CW'(-320 * ONE_I), 32'h0, CW'(-ONE_I), 1'b1, 1'b1, 1'b0},
        '{VIEW_PINHOLE, CMAX, CMIN, CMAX, 1'b1, 1'b0, 1'b0},
        '{VIEW_PINHOLE, CMIN, CMAX, CMIN, 1'b0, 1'b0, 1'b0},
        '{VIEW_PINHOLE, CMIN, CMIN, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        // empty windows
        '{VIEW_NARROW, 32'h0, 32'h0, ONE, 1'b0, 1'b1, 1'b0},
        '{VIEW_NARROW, 32'h0, 32'h0, CW'(-ONE_I), 1'b1, 1'b1, 1'b0},
        '{VIEW_FLAT, 32'h0, 32'h0, ONE, 1'b0, 1'b1, 1'b0},
        '{VIEW_EXTREME, CMAX, CMAX, CMAX, 1'b1, 1'b0, 1'b0},
        '{VIEW_EXTREME, CMIN, CMIN, CMIN, 1'b0, 1'b0, 1'b0},
        '{VIEW_EXTREME, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0},
        '{VIEW_EXTREME, ONE, CW'(-ONE_I), ONE, 1'b0, 1'b0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [CW-1:0]  point_x;
    logic signed [CW-1:0]  point_y;
    logic signed [CW-1:0]  point_z;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [CW-1:0]  out_x;
    logic signed [CW-1:0]  out_y;
    logic signed [CW-1:0]  out_z;
    logic                  keep;
    logic                  out_frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // bench copy of the block's registers, updated on each accepted write
    logic [CFG_DATA_W-1:0] mat_cfg [MAT_REGS];
    logic [15:0]           width_cfg;
    logic [15:0]           height_cfg;

    // values the next load_config call writes
    logic [CFG_DATA_W-1:0] next_mat [MAT_REGS];
    logic [15:0]           next_width;
    logic [15:0]           next_height;

    point_result_t pending_results [$];
    matrix_mix_t   phase_mix;
    bit            no_gaps;
    int            error_count;
    int            stall_left;
    int            cycle_count;

    lidar_point_camera_view_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .keep          (keep),
        .out_frame_end (out_frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Projection predictor. All sums are exact in 128 bits; the divisions
    // u = Y0/Y2, v = Y1/Y2 become cross-multiplied comparisons with the
    // depth magnitude, the numerator flipped when the depth is negative.
    // ------------------------------------------------------------------
    function automatic logic signed [127:0] wide_mul(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic logic signed [MAT_W-1:0] mat_entry(input int row, input int col);
        logic [CFG_DATA_W-1:0] pair;
        pair = mat_cfg[row * 2 + col / 2];
        return (col % 2 != 0) ? pair[63:32] : pair[31:0];
    endfunction

    function automatic logic signed [127:0] project_row(input int row,
                                                        input logic signed [CW-1:0] px,
                                                        input logic signed [CW-1:0] py,
                                                        input logic signed [CW-1:0] pz);
        return wide_mul(mat_entry(row, 0), px) + wide_mul(mat_entry(row, 1), py)
             + wide_mul(mat_entry(row, 2), pz) + wide_mul(mat_entry(row, 3), ONE);
    endfunction

    function automatic logic predict_keep(input logic signed [CW-1:0] px,
                                          input logic signed [CW-1:0] py,
                                          input logic signed [CW-1:0] pz);
        logic signed [127:0] y0, y1, y2, depth, nu, nv, half_u, half_v, bound_u, bound_v;
        y0 = project_row(0, px, py, pz);
        y1 = project_row(1, px, py, pz);
        y2 = project_row(2, px, py, pz);
        if (y2 == 0)
            return 1'b0;                    // zero depth never projects
        depth   = (y2 < 0) ? -y2 : y2;
        nu      = (y2 < 0) ? -y0 : y0;
        nv      = (y2 < 0) ? -y1 : y1;
        half_u  = width_cfg >> 1;
        half_v  = height_cfg >> 1;
        bound_u = depth * half_u;
        bound_v = depth * half_v;
        return (nu >= -bound_u) && (nu < bound_u) && (nv >= -bound_v) && (nv < bound_v);
    endfunction

    // gap lengths: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_image_size();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'(2 * $urandom_range(1, 8));
            default: return 16'($urandom_range(2, 2000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Configuration channel. Called right after a rising edge; valid is
    // left high for back-to-back writes and lowered by load_config.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < MAT_REGS)
            mat_cfg[idx] = data;
        else if (idx == REG_IMAGE_WIDTH)
            width_cfg = data[15:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_cfg = data[15:0];
        // other codes are dropped by the block
    endtask

    task automatic load_config();
        for (int i = 0; i < MAT_REGS; i++)
            write_reg(CFG_IDX_W'(i), next_mat[i]);
        write_reg(REG_IMAGE_WIDTH, {{(CFG_DATA_W-16){1'b1}}, next_width});
        write_reg(REG_IMAGE_HEIGHT, {{(CFG_DATA_W-16){1'b1}}, next_height});
        // unused code with junk data must not disturb anything
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_CODE)),
                  {$urandom(), $urandom()});
        cfg_valid <= 1'b0;
    endtask

    // pinhole: u = x/z, v = y/z; depth_gain flips the depth sign if negative
    task automatic build_pinhole(input logic [CW-1:0] depth_gain);
        next_mat[REG_ROW0_COLS01] = {32'h0, ONE};
        next_mat[REG_ROW0_COLS23] = '0;
        next_mat[REG_ROW1_COLS01] = {ONE, 32'h0};
        next_mat[REG_ROW1_COLS23] = '0;
        next_mat[REG_ROW2_COLS01] = '0;
        next_mat[REG_ROW2_COLS23] = {32'h0, depth_gain};
    endtask

    task automatic build_view(input view_setting_t view);
        build_pinhole(ONE);
        next_width  = WIDTH_RESET;
        next_height = HEIGHT_RESET;
        case (view)
            VIEW_NARROW: next_width = 16'd1;
            VIEW_FLAT:   next_height = 16'd0;
            VIEW_EXTREME:
            begin
                next_mat[REG_ROW0_COLS01] = {CMIN, CMAX};
                next_mat[REG_ROW0_COLS23] = {CMAX, CMIN};
                next_mat[REG_ROW1_COLS01] = {CMAX, CMIN};
                next_mat[REG_ROW1_COLS23] = {CMIN, CMAX};
                next_mat[REG_ROW2_COLS01] = {CMAX, CMAX};
                next_mat[REG_ROW2_COLS23] = {CMIN, CMIN};
                next_width  = 16'hFFFF;
                next_height = 16'hFFFF;
            end
            default: ;
        endcase
    endtask

    task automatic build_random_view();
        case ($urandom_range(0, 3))
            0, 1: phase_mix = MIX_PINHOLE;
            2:    phase_mix = MIX_FULL_RANDOM;
            default: phase_mix = MIX_SMALL_RANDOM;
        endcase
        case (phase_mix)
            MIX_PINHOLE:
                build_pinhole($urandom_range(0, 1) ? ONE : CW'(-ONE_I));
            MIX_FULL_RANDOM:
                for (int i = 0; i < MAT_REGS; i++)
                    next_mat[i] = {$urandom(), $urandom()};
            default:
                for (int i = 0; i < MAT_REGS; i++)
                    next_mat[i] = {32'($urandom_range(0, 8 * ONE_I) - 4 * ONE_I),
                                   32'($urandom_range(0, 8 * ONE_I) - 4 * ONE_I)};
        endcase
        next_width  = pick_image_size();
        next_height = pick_image_size();
    endtask

    // ------------------------------------------------------------------
    // Point channel
    // ------------------------------------------------------------------
    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input logic [CW-1:0] pz, input logic fe,
                              input logic typed, input logic keep_typed);
        int gap;
        point_result_t entry;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        point_x   <= px;
        point_y   <= py;
        point_z   <= pz;
        frame_end <= fe;
        do
            @(posedge clk);
        while (in_stall);
        entry.px        = px;
        entry.py        = py;
        entry.pz        = pz;
        entry.keep_flag = typed ? keep_typed : predict_keep(px, py, pz);
        entry.last_flag = fe;
        pending_results.insert(pending_results.size(), entry);
    endtask

    // Point aimed at the pinhole window: pick pixel (u, v) just around the
    // window, a depth small enough not to overflow, then x = u*z, y = v*z
    // give or take one LSB so both sides of every edge get hit.
    task automatic make_aimed_point(output logic [CW-1:0] px, output logic [CW-1:0] py,
                                    output logic [CW-1:0] pz);
        longint half_u, half_v, u, v, depth, lim;
        half_u = width_cfg >> 1;
        half_v = height_cfg >> 1;
        u = longint'($urandom_range(0, 2 * half_u + 4)) - half_u - 2;
        v = longint'($urandom_range(0, 2 * half_v + 4)) - half_v - 2;
        lim = 64'h8000_0000 / (((half_u > half_v) ? half_u : half_v) + 3);
        if (lim > (1 << 22))
            lim = 1 << 22;
        depth = $urandom_range(1, lim);
        if ($urandom_range(0, 1))
            depth = -depth;
        if ($urandom_range(0, 9) == 0)
            depth = 0;
        px = CW'(u * depth + longint'($urandom_range(0, 2)) - 1);
        py = CW'(v * depth + longint'($urandom_range(0, 2)) - 1);
        pz = CW'(depth);
    endtask

    task automatic send_random_point();
        logic [CW-1:0] px, py, pz;
        int pick;
        pick = $urandom_range(0, 9);
        if (phase_mix == MIX_PINHOLE && pick < 8)
            make_aimed_point(px, py, pz);
        else if (pick < 5)
        begin
            // small coordinates, a few metres around the origin
            px = CW'($urandom_range(0, 16 * ONE_I) - 8 * ONE_I);
            py = CW'($urandom_range(0, 16 * ONE_I) - 8 * ONE_I);
            pz = CW'($urandom_range(0, 16 * ONE_I) - 8 * ONE_I);
        end
        else
        begin
            px = $urandom();
            py = $urandom();
            pz = $urandom();
        end
        send_point(px, py, pz, $urandom_range(0, 7) == 0, 1'b0, 1'b0);
    endtask

    // drop valid, let every queued result come out, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker and output stall generator. Inputs sampled at the
    // edge see the values from before it; stall is driven by NBA.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        point_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: x %h y %h z %h",
                       out_x, out_y, out_z);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_x !== want.px)
                begin
                    $error("out_x: expected %h, got %h", want.px, out_x);
                    error_count++;
                end
                if (out_y !== want.py)
                begin
                    $error("out_y: expected %h, got %h", want.py, out_y);
                    error_count++;
                end
                if (out_z !== want.pz)
                begin
                    $error("out_z: expected %h, got %h", want.pz, out_z);
                    error_count++;
                end
                if (keep !== want.keep_flag)
                begin
                    $error("keep: expected %b, got %b", want.keep_flag, keep);
                    error_count++;
                end
                if (out_frame_end !== want.last_flag)
                begin
                    $error("out_frame_end: expected %b, got %b", want.last_flag, out_frame_end);
                    error_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left = idle_len();
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** lidar_point_camera_view_filter: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        view_setting_t cur_view;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        point_x     = '0;
        point_y     = '0;
        point_z     = '0;
        frame_end   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        stall_left  = 0;
        no_gaps     = 1'b0;
        phase_mix   = MIX_PINHOLE;
        foreach (mat_cfg[i])
            mat_cfg[i] = '0;
        width_cfg   = WIDTH_RESET;
        height_cfg  = HEIGHT_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed list; the first rows run on the reset registers
        cur_view = VIEW_AS_RESET;
        foreach (DIRECTED_POINTS[i])
        begin
            if (DIRECTED_POINTS[i].setting != cur_view)
            begin
                wait_idle();
                cur_view = DIRECTED_POINTS[i].setting;
                build_view(cur_view);
                load_config();
            end
            send_point(DIRECTED_POINTS[i].px, DIRECTED_POINTS[i].py, DIRECTED_POINTS[i].pz,
                       DIRECTED_POINTS[i].fe, DIRECTED_POINTS[i].typed,
                       DIRECTED_POINTS[i].keep_typed);
        end

        // random phases, each on a fresh camera setup
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            wait_idle();
            no_gaps = ($urandom_range(0, 3) == 0);
            build_random_view();
            load_config();
            repeat (ITEMS_PER_RUN) send_random_point();
        end

        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("** lidar_point_camera_view_filter: PASSED **");
        else
            $display("** lidar_point_camera_view_filter: FAILED **");
        $finish;
    end

endmodule
